// ----- rtl/core/itrd_pkg.sv -----
// Shared constants, types and helper functions for the radix digit converter.
`timescale 1ns / 1ps
`default_nettype none

package itrd_pkg;

	// Sizing
	localparam int MAX_DIGITS   = 32;
	localparam int VALUE_BITS   = 31;
	localparam int ADDR_W       = $clog2(MAX_DIGITS);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int BIT_CNT_W    = $clog2(VALUE_BITS);
	localparam int BASE_W       = 8;
	localparam int REM_W        = 6;
	localparam int CAP_W        = 6;
	localparam int CHAR_W       = 7;
	localparam int STATUS_W     = 2;

	// Numeric constants
	localparam int RADIX_MIN    = 2;
	localparam int RADIX_MAX    = 36;
	localparam int DEC_DIGITS   = 10;
	localparam int CAP_RESET    = 33;
	localparam int CAP_OVERHEAD = 2;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_BAD_BASE = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    load;
		logic    div_init;
		logic    div_step;
		logic    store_digit;
		logic    rd_issue;
		logic    out_digit;
		logic    out_err;
		status_t err_code;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic base_bad;
		logic at_limit;
		logic quot_zero;
		logic div_last;
		logic rd_last;
		logic out_free;
	} sts_t;

	// Digit value to ASCII: 0-9 then A-Z, zero for anything out of range
	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [REM_W-1:0] d);
		logic [CHAR_W-1:0] w;
		w = CHAR_W'(d);
		if (d < REM_W'(DEC_DIGITS)) begin
			return w + ASCII_ZERO;
		end else if (d < REM_W'(RADIX_MAX)) begin
			return w - CHAR_W'(DEC_DIGITS) + ASCII_A;
		end
		return '0;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/integer_to_radix_digits.sv -----
// Top level of the integer to radix digit converter.
`timescale 1ns / 1ps
`default_nettype none

// Converts a non-negative 31-bit value to its digits in base 2..36, sent one
// beat per digit as ASCII ('0'-'9', 'A'-'Z'), most significant first, with
// last on the final digit. A bad base, or a value that needs more than
// buffer_capacity - 2 digits (capped at 31), gives one error beat instead. One item
// at a time: a bit-serial restoring divider produces each digit, with a limit
// check, the divide steps and a store per digit, then a store read and a
// result load per digit, plus any output stall. buffer_capacity resets to 33
// and the user must write it through the cfg channel only while the block is
// idle; the block does not enforce this.
module integer_to_radix_digits
	import itrd_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [CAP_W-1:0]      cfg_wdata,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire  [VALUE_BITS-1:0] value,
	input  wire  [BASE_W-1:0]     base,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic [CHAR_W-1:0]     digit_char,
	output logic                  last,
	output logic [STATUS_W-1:0]   status
);

	cmd_t cmd;
	sts_t sts;

	// Capacity writes are always taken
	assign cfg_ready = 1'b1;

	itrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	itrd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.value      (value),
		.base       (base),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_char (digit_char),
		.last       (last),
		.status     (status)
	);

endmodule

`default_nettype wire

// ----- rtl/core/itrd_ctrl.sv -----
// Sequencing state machine for the radix digit converter.
`timescale 1ns / 1ps
`default_nettype none

module itrd_ctrl
	import itrd_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	output logic      in_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_CHK      = 8'b0000_0010,
		S_DIV      = 8'b0000_0100,
		S_STORE    = 8'b0000_1000,
		S_READ     = 8'b0001_0000,
		S_EMIT     = 8'b0010_0000,
		S_ERR_BASE = 8'b0100_0000,
		S_ERR_OVF  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// Input beats are taken only between conversions
	assign in_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.err_code = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.base_bad ? S_ERR_BASE : S_CHK;
				end
			end
			S_CHK: begin
				if (sts.at_limit) begin
					state_d = S_ERR_OVF;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				cmd.store_digit = 1'b1;
				state_d         = sts.quot_zero ? S_READ : S_CHK;
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_digit = 1'b1;
					state_d       = sts.rd_last ? S_IDLE : S_READ;
				end
			end
			S_ERR_BASE: begin
				cmd.err_code = ST_BAD_BASE;
				if (sts.out_free) begin
					cmd.out_err = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_ERR_OVF: begin
				cmd.err_code = ST_OVERFLOW;
				if (sts.out_free) begin
					cmd.out_err = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/itrd_dp.sv -----
// Datapath: restoring divider, digit store, capacity register and result register.
`timescale 1ns / 1ps
`default_nettype none

module itrd_dp
	import itrd_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire cmd_t             cmd,
	output sts_t                  sts,
	input  wire  [VALUE_BITS-1:0] value,
	input  wire  [BASE_W-1:0]     base,
	input  wire                   cfg_we,
	input  wire  [CAP_W-1:0]      cfg_wdata,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic [CHAR_W-1:0]     digit_char,
	output logic                  last,
	output logic [STATUS_W-1:0]   status
);

	logic [CAP_W-1:0]      cap_q;
	logic [REM_W-1:0]      base_q;
	logic [VALUE_BITS-1:0] quot_q;
	logic [REM_W-1:0]      rem_q;
	logic [BIT_CNT_W-1:0]  bit_q;
	logic [CNT_W-1:0]      n_q;
	logic [ADDR_W-1:0]     rd_ptr_q;
	logic [REM_W-1:0]      rd_data_q;
	logic [REM_W-1:0]      store_mem [MAX_DIGITS];
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     digit_char_q;
	logic                  last_q;
	status_t               status_q;

	logic [CAP_W-1:0]      cap_sub;
	logic [CAP_W-1:0]      limit;
	logic [REM_W:0]        trial;
	logic [REM_W:0]        diff;
	logic                  ge;
	logic [REM_W-1:0]      rem_next;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(CAP_RESET);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Digit limit: capacity minus two, floored at zero, capped at store depth minus one
	always_comb begin
		cap_sub = cap_q - CAP_W'(CAP_OVERHEAD);
		if (cap_q < CAP_W'(CAP_OVERHEAD)) begin
			limit = '0;
		end else if (32'(cap_sub) > MAX_DIGITS - 1) begin
			limit = CAP_W'(MAX_DIGITS - 1);
		end else begin
			limit = cap_sub;
		end
	end

	// One restoring division step: shift in the next quotient bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, quot_q[VALUE_BITS-1]};
		diff     = trial - {1'b0, base_q};
		ge       = (trial >= {1'b0, base_q});
		rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
	end

	// Divider and digit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q    <= '0;
			n_q      <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (cmd.load) begin
				n_q <= '0;
			end else if (cmd.store_digit) begin
				n_q <= n_q + CNT_W'(1);
			end
			if (cmd.div_init) begin
				bit_q <= '0;
			end else if (cmd.div_step) begin
				bit_q <= bit_q + BIT_CNT_W'(1);
			end
			if (cmd.store_digit) begin
				rd_ptr_q <= n_q[ADDR_W-1:0];
			end else if (cmd.out_digit) begin
				rd_ptr_q <= rd_ptr_q - ADDR_W'(1);
			end
		end
	end

	// Divider payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quot_q <= value;
			base_q <= base[REM_W-1:0];
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[VALUE_BITS-2:0], ge};
		end
		if (cmd.div_init) begin
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
		end
	end

	// Digit store, least significant digit first
	always_ff @(posedge clk) begin
		if (cmd.store_digit) begin
			store_mem[n_q[ADDR_W-1:0]] <= rem_q;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= store_mem[rd_ptr_q];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_digit || cmd.out_err) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_digit) begin
			digit_char_q <= digit_ascii(rd_data_q);
			last_q       <= (rd_ptr_q == '0);
			status_q     <= ST_OK;
		end else if (cmd.out_err) begin
			digit_char_q <= '0;
			last_q       <= 1'b1;
			status_q     <= cmd.err_code;
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = digit_char_q;
	assign last       = last_q;
	assign status     = status_q;

	// Status to the controller
	always_comb begin
		sts.base_bad  = (base < BASE_W'(RADIX_MIN)) || (base > BASE_W'(RADIX_MAX));
		sts.at_limit  = (32'(n_q) == 32'(limit));
		sts.quot_zero = (quot_q == '0);
		sts.div_last  = (bit_q == BIT_CNT_W'(VALUE_BITS - 1));
		sts.rd_last   = (rd_ptr_q == '0);
		sts.out_free  = !out_valid_q || !out_stall;
	end

`ifndef NO_ASSERTIONS
	// A result is loaded only when the result register can take it
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_digit || cmd.out_err) |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a pending beat");

	// Reads stay within the digits of the current conversion
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |-> (CNT_W'(rd_ptr_q) < n_q))
		else $error("digit read beyond stored count");

	// Divider partial remainder stays below the base
	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < base_q))
		else $error("divider remainder not below base");

	// Digit count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_digit |-> (32'(n_q) < MAX_DIGITS - 1))
		else $error("digit count overflow");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the integer to radix digit converter.
`timescale 1ns / 1ps

module tb_top;
	import itrd_pkg::*;

	localparam longint CYCLE_LIMIT = 4_000_000;
	localparam longint MAXV = (64'd1 << VALUE_BITS) - 1;

	// One expected output beat
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              fin;
		status_t           st;
	} digit_beat_t;

	// Predicts digit beats per accepted conversion and checks them in order
	class radix_digit_checker;
		digit_beat_t pending[$];
		bit [CAP_W-1:0] capacity;
		int errors, n_items, n_digits, n_bad_base, n_overflow;

		function new();
			capacity = CAP_W'(CAP_RESET);
		endfunction

		function void set_capacity(bit [CAP_W-1:0] c);
			capacity = c;
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH at %0t: %s", $time, msg);
		endtask

		// Repeated division, digits pushed most significant first
		function void note_conversion(bit [VALUE_BITS-1:0] v, bit [BASE_W-1:0] b);
			bit [REM_W-1:0] digs[$];
			longint q;
			int lim, n;
			bit [REM_W-1:0] d;
			n_items++;
			if (b < RADIX_MIN || b > RADIX_MAX) begin
				pending.push_back(digit_beat_t'{'0, 1'b1, ST_BAD_BASE});
				return;
			end
			lim = (capacity >= CAP_OVERHEAD) ? int'(capacity) - CAP_OVERHEAD : 0;
			if (lim > MAX_DIGITS - 1) lim = MAX_DIGITS - 1;
			q = v;
			n = 0;
			// limit is checked before every digit, the lone digit of zero too
			do begin
				if (n == lim) begin
					pending.push_back(digit_beat_t'{'0, 1'b1, ST_OVERFLOW});
					return;
				end
				digs.push_back(REM_W'(q % b));
				q = q / b;
				n++;
			end while (q > 0);
			for (int k = n - 1; k >= 0; k--) begin
				d = digs[k];
				pending.push_back(digit_beat_t'{
					(d < DEC_DIGITS) ? CHAR_W'(ASCII_ZERO + d)
					                 : CHAR_W'(ASCII_A + d - DEC_DIGITS),
					k == 0, ST_OK});
			end
		endfunction

		task check_beat(logic [CHAR_W-1:0] ch, logic fin, logic [STATUS_W-1:0] st);
			digit_beat_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected beat char=%0h last=%0b status=%0d",
					ch, fin, st));
				return;
			end
			want = pending.pop_front();
			if (ch !== want.ch)
				report($sformatf("digit_char %0h, want %0h", ch, want.ch));
			if (fin !== want.fin)
				report($sformatf("last %0b, want %0b", fin, want.fin));
			if (st !== want.st)
				report($sformatf("status %0d, want %0d", st, want.st));
			case (want.st)
				ST_OK:       n_digits++;
				ST_BAD_BASE: n_bad_base++;
				default:     n_overflow++;
			endcase
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic [VALUE_BITS-1:0] value = '0;
	logic [BASE_W-1:0] base = '0;
	logic out_stall = 1'b0;
	wire cfg_ready, in_stall, out_valid, last;
	wire [CHAR_W-1:0] digit_char;
	wire [STATUS_W-1:0] status;

	radix_digit_checker conv_check = new();
	longint cyc = 0;
	int hold_left = 0;
	bit quiet_run = 1'b0;
	int n_caps = 0;

	integer_to_radix_digits dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.base       (base),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_char (digit_char),
		.last       (last),
		.status     (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Output monitor and watchdog
	always @(posedge clk) begin
		cyc++;
		if (arst_n && out_valid && !out_stall)
			conv_check.check_beat(digit_char, last, status);
		if (cyc > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = !quiet_run && ($urandom_range(99) < 6);
		end
	end

	// Offer one conversion, with occasional idle cycles ahead of it
	task automatic send_item(bit [VALUE_BITS-1:0] v, bit [BASE_W-1:0] b);
		while (!quiet_run && $urandom_range(99) < 6) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		value = v;
		base = b;
		do @(posedge clk); while (in_stall);
		conv_check.note_conversion(v, b);
	endtask

	// Stop offering and wait for every predicted beat
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (conv_check.pending.size() > 0) @(posedge clk);
	endtask

	task automatic write_capacity(bit [CAP_W-1:0] c);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_wdata = c;
		do @(posedge clk); while (!cfg_ready);
		conv_check.set_capacity(c);
		n_caps++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic bit [BASE_W-1:0] pick_base();
		if ($urandom_range(99) < 85) return BASE_W'($urandom_range(RADIX_MIN, RADIX_MAX));
		return BASE_W'($urandom_range(255));
	endfunction

	// Mix of zero, small values, powers of the base and their neighbors, wide values
	function automatic bit [VALUE_BITS-1:0] pick_value(int b);
		int r, k;
		longint p;
		r = $urandom_range(99);
		if (r < 10) return '0;
		if (r < 30) return VALUE_BITS'($urandom_range(b * b));
		if (r < 55) begin
			k = $urandom_range(1, MAX_DIGITS - 1);
			p = 1;
			while (k > 0 && p * b <= MAXV) begin
				p = p * b;
				k--;
			end
			return $urandom_range(1) ? VALUE_BITS'(p) : VALUE_BITS'(p - 1);
		end
		if (r < 80) return VALUE_BITS'($urandom() >> $urandom_range(1, 31));
		return VALUE_BITS'($urandom());
	endfunction

	initial begin
		int caps[10];
		int cap_now;
		bit [BASE_W-1:0] b;
		caps = '{3, 12, 63, 0, 33, 2, -1, 1, 25, 33};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed checks at the reset capacity
		send_item('0, 10);
		send_item(VALUE_BITS'(MAXV), 2);
		send_item(VALUE_BITS'(MAXV), 36);
		send_item(VALUE_BITS'(MAXV), 16);
		send_item(VALUE_BITS'(1 << 30), 2);
		send_item(1, 2);
		send_item(1234567890, 10);
		send_item(35, 36);
		send_item(9, 10);
		send_item(10, 10);
		send_item(VALUE_BITS'(MAXV), 0);
		send_item(5, 1);
		send_item('0, 37);
		send_item(VALUE_BITS'(MAXV), 255);

		for (int p = 0; p < 10; p++) begin
			drain();
			repeat (4) @(posedge clk);
			cap_now = (caps[p] < 0) ? $urandom_range(3, 33) : caps[p];
			write_capacity(CAP_W'(cap_now));
			quiet_run = (p == 4);

			// limit edges at the smallest capacities
			if (cap_now == 3) begin
				send_item('0, 10);
				send_item(7, 8);
				send_item(8, 8);
			end
			if (cap_now == 0) send_item('0, 2);

			for (int i = 0; i < 50; i++) begin
				if (p == 1 && i == 10) hold_left = 1200;
				if (p == 6 && i == 25) drain();
				b = pick_base();
				send_item(pick_value((b >= RADIX_MIN && b <= RADIX_MAX) ? int'(b) : 10), b);
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (conv_check.pending.size() > 0)
			conv_check.report($sformatf("%0d beats never came", conv_check.pending.size()));

		$display("covered %0d conversions: %0d digit beats, %0d bad-base, %0d overflow",
			conv_check.n_items, conv_check.n_digits, conv_check.n_bad_base,
			conv_check.n_overflow);
		$display("%0d capacity writes incl. 0, 2, 3, 63; hold-off and drain pause; %0d cycles",
			n_caps, cyc);
		if (conv_check.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", conv_check.errors);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
